>>> rtl/core/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg
// Shared constants and controller/datapath command and status types for the gray stretch.
// ----------------------------------------------------------------------------
package mmg_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 16;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned GRAY_W         = 8;
  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef struct packed {
    logic measure;
    logic convert;
    logic step;
    logic emit;
  } mmg_cmd_t;

  typedef struct packed {
    logic direct;
    logic out_busy;
  } mmg_sts_t;

endpackage

>>> rtl/core/mmg_if.sv
// ----------------------------------------------------------------------------
// mmg_if
// Stream interfaces for pixel words in and gray words out.
// ----------------------------------------------------------------------------
interface mmg_pix_if
  import mmg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SAMPLE_W-1:0] pixel_value;
  logic                frame_end;

  modport source (output valid, operation, pixel_value, frame_end, input ready);
  modport sink   (input valid, operation, pixel_value, frame_end, output ready);
endinterface

interface mmg_gray_if
  import mmg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_level;
  logic              frame_last;

  modport source (output valid, gray_level, frame_last, input ready);
  modport sink   (input valid, gray_level, frame_last, output ready);
endinterface

>>> rtl/core/minmax_normalize_to_gray8_core.sv
// ----------------------------------------------------------------------------
// minmax_normalize_to_gray8_core
// Min/max contrast stretch of unsigned pixels to 8-bit gray.
// ----------------------------------------------------------------------------
// Measure word: updates the range bounds, no result.
// Convert word: result goes straight to the output register if at or outside the
// range bounds or flat, else after an eight-step restoring divider; output stalls delay both.
// Input ready rises in the same cycle as the result enters the output register.
// Reset (async, active low) clears range bounds, the seed flag, output valid and sequencer state.
module minmax_normalize_to_gray8_core
  import mmg_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmg_pix_if.sink    in_i,
  mmg_gray_if.source out_o
);

  mmg_cmd_t cmd;
  mmg_sts_t sts;

  mmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .operation_i (in_i.operation),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mmg_datapath #(.PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pixel_value_i (in_i.pixel_value),
    .frame_end_i   (in_i.frame_end),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .gray_level_o  (out_o.gray_level),
    .frame_last_o  (out_o.frame_last)
  );

endmodule

>>> rtl/core/mmg_datapath.sv
// ----------------------------------------------------------------------------
// mmg_datapath
// Range tracking, restoring divider (one quotient bit a cycle), output register.
// ----------------------------------------------------------------------------
module mmg_datapath
  import mmg_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmg_cmd_t            cmd_i,
  output mmg_sts_t            sts_o,
  input  logic [SAMPLE_W-1:0] pixel_value_i,
  input  logic                frame_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [GRAY_W-1:0]   gray_level_o,
  output logic                frame_last_o
);

  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned NW = PB + GRAY_W;

  logic [PB-1:0] v;
  logic [PB-1:0] min_q, max_q, span_q, rem_q;
  logic          started_q;
  logic [GRAY_W-1:0] nlo_q, quo_q;
  logic          last_q;
  logic          out_valid_q;
  logic [GRAY_W-1:0] gray_q;
  logic          flast_q;
  logic [PB-1:0] diff;
  logic [NW-1:0] num;
  logic          flat, low, high;
  logic [PB:0]   rw;
  logic          ge;

  assign v    = PB'(pixel_value_i);
  assign diff = v - min_q;
  assign num  = ({diff, GRAY_W'(0)}) - NW'(diff);
  assign flat = (max_q <= min_q);
  assign low  = (v <= min_q);
  assign high = (v >= max_q);
  assign rw   = {rem_q, nlo_q[GRAY_W-1]};
  assign ge   = (rw >= {1'b0, span_q});

  assign sts_o.direct   = flat | low | high;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= '0;
      max_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.measure) begin
        if (!started_q || v < min_q) min_q <= v;
        if (!started_q || v > max_q) max_q <= v;
        started_q <= ~frame_end_i;
      end
      if (cmd_i.convert) started_q <= 1'b0;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.convert) begin
      last_q <= frame_end_i;
      span_q <= max_q - min_q;
      rem_q  <= num[NW-1:GRAY_W];
      nlo_q  <= num[GRAY_W-1:0];
      quo_q  <= (flat | low) ? '0 : GRAY_MAX;
    end else if (cmd_i.step) begin
      rem_q <= ge ? PB'(rw - {1'b0, span_q}) : rw[PB-1:0];
      nlo_q <= {nlo_q[GRAY_W-2:0], 1'b0};
      quo_q <= {quo_q[GRAY_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      gray_q  <= quo_q;
      flast_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gray_level_o = gray_q;
  assign frame_last_o = flast_q;

endmodule

>>> rtl/core/mmg_ctrl.sv
// ----------------------------------------------------------------------------
// mmg_ctrl
// Sequencer: accepts words, runs eight divide steps unless the result is direct, hands result to output.
// ----------------------------------------------------------------------------
module mmg_ctrl
  import mmg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     operation_i,
  input  mmg_sts_t sts_i,
  output mmg_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_e;

  state_e     state_q;
  logic [2:0] cnt_q;
  logic       acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  assign cmd_o.measure = acc & (operation_i == OP_MEASURE);
  assign cmd_o.convert = acc & (operation_i == OP_CONVERT);
  assign cmd_o.step    = (state_q == S_DIV);
  assign cmd_o.emit    = (state_q == S_OUT) & ~sts_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.convert) begin
            state_q <= sts_i.direct ? S_OUT : S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_q <= S_OUT;
        end
        S_OUT: begin
          if (cmd_o.emit) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/mmg_checker.sv
// ----------------------------------------------------------------------------
// mmg_checker
// Port-level checks on the gray stretch core.
// ----------------------------------------------------------------------------
module mmg_checker
  import mmg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              operation_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [GRAY_W-1:0] gray_level_i
);

  logic conv_acc, meas_acc;
  assign conv_acc = in_valid_i & in_ready_i & (operation_i == OP_CONVERT);
  assign meas_acc = in_valid_i & in_ready_i & (operation_i == OP_MEASURE);

  a_busy_after_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_acc |=> !in_ready_i) else $error("ready after convert word");

  a_no_result_on_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meas_acc && !out_valid_i) |=> !out_valid_i) else $error("result from measure word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(gray_level_i)))
    else $error("output word dropped");

endmodule

bind minmax_normalize_to_gray8_core mmg_checker u_mmg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .operation_i  (in_i.operation),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .gray_level_i (out_o.gray_level)
);

>>> tb/minmax_normalize_to_gray8_core_test.sv
// ----------------------------------------------------------------------------
// minmax_normalize_to_gray8_core_test
// Drives measure and convert passes of pixel words into the gray stretch core,
// predicts each gray word from a tracked frame range and checks the results in
// order, with random idling on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module minmax_normalize_to_gray8_core_test;
  import mmg_pkg::*;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              last;
  } gray_word_t;

  logic clk_i;
  logic rst_ni;

  mmg_pix_if  pix ();
  mmg_gray_if gray ();

  minmax_normalize_to_gray8_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pix.sink),
    .out_o (gray.source)
  );

  logic [SAMPLE_W-1:0] lo_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic                seeded_q;
  gray_word_t          gray_q[$];
  int                  n_errors = 0;
  int                  cycle_cnt = 0;
  bit                  idle_en;
  int                  hold_cycles;
  int                  rdy_idle;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic logic [GRAY_W-1:0] stretch_gray(input logic [SAMPLE_W-1:0] v);
    logic [31:0] num;
    if (hi_q <= lo_q || v <= lo_q) return '0;
    if (v >= hi_q) return GRAY_MAX;
    num = 32'd255 * (v - lo_q);
    return GRAY_W'(num / (hi_q - lo_q));
  endfunction

  task automatic predict(input logic op, input logic [SAMPLE_W-1:0] v, input logic fe);
    if (op == OP_MEASURE) begin
      if (!seeded_q) begin
        lo_q = v;
        hi_q = v;
        seeded_q = 1'b1;
      end else begin
        if (v < lo_q) lo_q = v;
        if (v > hi_q) hi_q = v;
      end
      if (fe) seeded_q = 1'b0;
    end else begin
      seeded_q = 1'b0;
      gray_q.push_back('{gray: stretch_gray(v), last: fe});
    end
  endtask

  task automatic send_pixel(input logic op, input logic [SAMPLE_W-1:0] v, input logic fe);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.operation   <= op;
    pix.pixel_value <= v;
    pix.frame_end   <= fe;
    do @(posedge clk_i); while (!pix.ready);
    predict(op, v, fe);
  endtask

  task automatic finish_input;
    pix.valid <= 1'b0;
  endtask

  task automatic wait_drained;
    while (gray_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_frame(input int n, input logic [SAMPLE_W-1:0] base,
                            input logic [SAMPLE_W-1:0] spread);
    logic [SAMPLE_W-1:0] px[$];
    logic [SAMPLE_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      v = (spread == 0) ? base : SAMPLE_W'(base + $urandom_range(0, spread));
      px.push_back(v);
    end
    foreach (px[i]) send_pixel(OP_MEASURE, px[i], i == n - 1);
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(0, 5) == 0) ? SAMPLE_W'($urandom) : px[$urandom_range(0, n - 1)];
      send_pixel(OP_CONVERT, v, i == n - 1);
    end
  endtask

  task automatic test_directed;
    send_pixel(OP_CONVERT, 16'hffff, 1'b1);
    send_pixel(OP_CONVERT, 16'h0000, 1'b0);
    send_pixel(OP_MEASURE, 16'h0000, 1'b0);
    send_pixel(OP_MEASURE, 16'hffff, 1'b1);
    send_pixel(OP_CONVERT, 16'h0000, 1'b0);
    send_pixel(OP_CONVERT, 16'hffff, 1'b0);
    send_pixel(OP_CONVERT, 16'h8000, 1'b0);
    send_pixel(OP_CONVERT, 16'h0001, 1'b1);
    send_pixel(OP_MEASURE, 16'h1000, 1'b0);
    send_pixel(OP_MEASURE, 16'h2000, 1'b0);
    send_pixel(OP_CONVERT, 16'h0fff, 1'b0);
    send_pixel(OP_CONVERT, 16'h2001, 1'b0);
    send_pixel(OP_CONVERT, 16'h1800, 1'b1);
    send_pixel(OP_MEASURE, 16'h5555, 1'b0);
    send_pixel(OP_MEASURE, 16'h5555, 1'b1);
    send_pixel(OP_CONVERT, 16'h5555, 1'b0);
    send_pixel(OP_CONVERT, 16'haaaa, 1'b1);
    send_pixel(OP_MEASURE, 16'h0100, 1'b0);
    send_pixel(OP_MEASURE, 16'h0101, 1'b1);
    send_pixel(OP_CONVERT, 16'h0100, 1'b0);
    send_pixel(OP_CONVERT, 16'h0101, 1'b1);
    finish_input();
    wait_drained();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_cycles = 300;
        while (hold_cycles > 0) begin
          @(posedge clk_i);
          hold_cycles--;
        end
      end
      send_frame(8, 16'h0400, 16'h0fff);
    join
    finish_input();
    wait_drained();
  endtask

  task automatic test_random;
    int n;
    int sent;
    sent = 0;
    while (sent < 520) begin
      n = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0:       send_frame(n, SAMPLE_W'($urandom), 16'h0000);
        1:       send_frame(n, 16'h0000, 16'hffff);
        2: begin
          repeat (n) send_pixel(1'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                                1'($urandom_range(0, 1)));
          n = n / 2;
        end
        default: send_frame(n, SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(1, 4000)));
      endcase
      sent += 2 * n;
      if (sent > 440) idle_en = 1'b0;
    end
    finish_input();
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray.ready <= 1'b0;
      rdy_idle   <= 0;
    end else if (hold_cycles > 0) begin
      gray.ready <= 1'b0;
    end else if (rdy_idle > 0) begin
      gray.ready <= 1'b0;
      rdy_idle   <= rdy_idle - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      gray.ready <= 1'b0;
      rdy_idle   <= $urandom_range(0, 18);
    end else begin
      gray.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    gray_word_t got;
    gray_word_t want;
    if (rst_ni && gray.valid && gray.ready) begin
      got = '{gray: gray.gray_level, last: gray.frame_last};
      if (gray_q.size() == 0) begin
        report($sformatf("unexpected word gray=%0d last=%0b", got.gray, got.last));
      end else begin
        want = gray_q.pop_front();
        if (got.gray !== want.gray)
          report($sformatf("gray_level %0d, want %0d", got.gray, want.gray));
        if (got.last !== want.last)
          report($sformatf("frame_last %0b, want %0b", got.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    pix.valid       = 1'b0;
    pix.operation   = OP_MEASURE;
    pix.pixel_value = '0;
    pix.frame_end   = 1'b0;
    lo_q            = '0;
    hi_q            = '0;
    seeded_q        = 1'b0;
    hold_cycles     = 0;
    idle_en         = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    if (gray_q.size() != 0) report($sformatf("%0d words never arrived", gray_q.size()));
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
